[rtl/core/bps_pkg.sv]
package bps_pkg;

    localparam int unsigned COUNT_W         = 8;
    localparam int unsigned HALF_PERIOD_W   = 16;
    localparam int unsigned DEFAULT_PERIOD  = 100;
    localparam int unsigned NUM_SLOTS       = 2;

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [COUNT_W-1:0]       beep_count;
        logic [HALF_PERIOD_W-1:0] half_period;
    } bps_in_t;

    typedef struct packed {
        logic buzzer_on;
        logic busy_res;
        logic request_dropped;
    } bps_out_t;

endpackage

[rtl/core/beep_pattern_sequencer.sv]
// Buzzer beep sequencer.
// Input channel (in_valid/in_ready/in_data) takes one word per item: a timer
// tick or a beep request carrying a beep count and a half-period in ticks.
// Output channel (out_valid/out_ready/out_data) returns exactly one word per
// input word: buzzer level, busy flag and a dropped-request flag.
// A running pattern parks up to two further requests; a third is dropped.
// cfg_we/cfg_wdata write the enable register; with enable low, requests are
// ignored. Write it only while no words are in flight.
// From input acceptance the word waits in the input register; once the output
// register is free, the state update and the fill of the output register
// happen at the same edge. Throughput is one word per cycle while the receiver
// does not stall; the compare and increment of the tick counter are combinational.
// Reset clears the pattern state, the waiting slots and the valid flags of both
// pipeline registers, and sets enable to 1.
// When the receiver stalls, the output register holds its word and the input
// register still fills; in_ready drops once both are occupied.
module beep_pattern_sequencer #(
    parameter int unsigned PERIOD_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bps_pkg::bps_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bps_pkg::bps_out_t out_data,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);
    import bps_pkg::*;

    logic      enable_reg;
    logic      stage_valid_reg;
    bps_in_t   stage_data_reg;
    logic      out_valid_reg;
    bps_out_t  out_data_reg;
    bps_out_t  result;
    logic      step;
    logic      out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign step     = stage_valid_reg && out_free;
    assign in_ready = !stage_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            enable_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_data_reg <= in_data;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    bps_engine #(
        .PERIOD_WIDTH(PERIOD_WIDTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .enable (enable_reg),
        .item   (stage_data_reg),
        .result (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/core/bps_engine.sv]
module bps_engine #(
    parameter int unsigned PERIOD_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             enable,
    input  bps_pkg::bps_in_t item,
    output bps_pkg::bps_out_t result
);
    import bps_pkg::*;

    localparam logic [PERIOD_WIDTH-1:0] DefPeriod = PERIOD_WIDTH'(DEFAULT_PERIOD);

    logic                    running_reg,  running_next;
    logic                    drive_reg,    drive_next;
    logic [PERIOD_WIDTH-1:0] tick_reg,     tick_next;
    logic [PERIOD_WIDTH-1:0] period_reg,   period_next;
    logic [COUNT_W-1:0]      beeps_reg,    beeps_next;
    logic [NUM_SLOTS-1:0]    slot_valid_reg, slot_valid_next;
    logic [COUNT_W-1:0]      slot_count_reg  [NUM_SLOTS];
    logic [PERIOD_WIDTH-1:0] slot_period_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]    slot_write;

    logic [PERIOD_WIDTH-1:0] req_period;
    logic [PERIOD_WIDTH-1:0] tick_inc;
    logic                    load_en;
    logic [COUNT_W-1:0]      load_count;
    logic [PERIOD_WIDTH-1:0] load_period;
    logic                    dropped;

    assign req_period = PERIOD_WIDTH'(item.half_period);
    assign tick_inc   = tick_reg + PERIOD_WIDTH'(1);

    always_comb
    begin
        running_next    = running_reg;
        drive_next      = drive_reg;
        tick_next       = tick_reg;
        beeps_next      = beeps_reg;
        slot_valid_next = slot_valid_reg;
        slot_write      = '0;
        load_en         = 1'b0;
        load_count      = item.beep_count;
        load_period     = req_period;
        dropped         = 1'b0;

        if (item.action == ACT_REQUEST)
        begin
            if (enable)
            begin
                priority if (!running_reg)
                begin
                    running_next = 1'b1;
                    drive_next   = 1'b1;
                    load_en      = 1'b1;
                end
                else if (!slot_valid_reg[0])
                begin
                    slot_valid_next[0] = 1'b1;
                    slot_write[0]      = 1'b1;
                end
                else if (!slot_valid_reg[1])
                begin
                    slot_valid_next[1] = 1'b1;
                    slot_write[1]      = 1'b1;
                end
                else
                begin
                    dropped = 1'b1;
                end
            end
        end
        else if (running_reg)
        begin
            tick_next = tick_inc;
            if (tick_inc == period_reg)
            begin
                tick_next = '0;
                if (!drive_reg)
                begin
                    drive_next = 1'b1;
                end
                else
                begin
                    drive_next = 1'b0;
                    if (beeps_reg == '0)
                    begin
                        // Pattern finished: load slot 0 if it waits, else slot 1.
                        priority if (slot_valid_reg[0])
                        begin
                            slot_valid_next[0] = 1'b0;
                            load_en            = 1'b1;
                            load_count         = slot_count_reg[0];
                            load_period        = slot_period_reg[0];
                        end
                        else if (slot_valid_reg[1])
                        begin
                            slot_valid_next[1] = 1'b0;
                            load_en            = 1'b1;
                            load_count         = slot_count_reg[1];
                            load_period        = slot_period_reg[1];
                        end
                        else
                        begin
                            running_next = 1'b0;
                        end
                    end
                    else
                    begin
                        beeps_next = beeps_reg - COUNT_W'(1);
                    end
                end
            end
        end

        // A zero count counts as one beep, and a zero period as the default.
        if (load_en)
        begin
            beeps_next  = (load_count == '0) ? '0 : load_count - COUNT_W'(1);
        end
    end

    assign period_next = !load_en ? period_reg :
                         (load_period == '0) ? DefPeriod : load_period;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            drive_reg      <= 1'b0;
            tick_reg       <= '0;
            period_reg     <= '0;
            beeps_reg      <= '0;
            slot_valid_reg <= '0;
        end
        else if (step)
        begin
            running_reg    <= running_next;
            drive_reg      <= drive_next;
            tick_reg       <= tick_next;
            period_reg     <= period_next;
            beeps_reg      <= beeps_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (step && slot_write[i])
            begin
                slot_count_reg[i]  <= item.beep_count;
                slot_period_reg[i] <= req_period;
            end
        end
    end

    assign result.buzzer_on       = drive_next;
    assign result.busy_res        = running_next;
    assign result.request_dropped = dropped;

endmodule
